[sv/kst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed slot table package
// Field widths, operation and status codes, and the command bundle that the
// controller hands to the datapath.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int ENTRIES_DEF = 64;

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 16;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;

  // A stored word is the valid mark, the key and the handle.
  localparam int WORD_W = 1 + KEY_W + HANDLE_W;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_MISS = 2'd3;

  typedef struct packed {
    logic load;  // capture the request and clear the scan trackers
    logic rd;    // read the slot at the scan address
    logic resp;  // settle the result and write the table back
    logic wipe;  // write an empty slot at the scan address
  } kst_cmd_t;

endpackage

[sv/kst_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/kst_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed slot table controller
// Sequences the clearing pass after reset and the slot scan of each request.
// ----------------------------------------------------------------------------
module kst_ctrl import kst_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  output logic                       done_o,
  output kst_cmd_t                   cmd_o,
  output logic [$clog2(ENTRIES)-1:0] addr_o
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             done_q;
  kst_cmd_t         cmd;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd     = '0;
    case (state_q)
      S_CLEAR: begin
        cmd.wipe = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cnt_d    = '0;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        cmd.resp = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= cmd.resp;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign cmd_o  = cmd;
  assign addr_o = cnt_q;

endmodule

[sv/kst_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed slot table datapath
// Holds the slot memory, tracks the first match and first free slot during a
// scan, and forms the result and the write-back.
// ----------------------------------------------------------------------------
module kst_dpath import kst_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kst_cmd_t                   cmd_i,
  input  logic [$clog2(ENTRIES)-1:0] addr_i,
  input  logic [KIND_W-1:0]          kind_i,
  input  logic [KEY_W-1:0]           key_i,
  input  logic [HANDLE_W-1:0]        handle_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic [HANDLE_W-1:0]        handle_out_o,
  output logic [SLOT_W-1:0]          slot_o
);

  localparam int IDX_W = $clog2(ENTRIES);

  // Request captured at acceptance.
  logic [KIND_W-1:0]   kind_q;
  logic [KEY_W-1:0]    key_q;
  logic [HANDLE_W-1:0] handle_q;

  // Read tag: data on the RAM output belongs to rd_idx_q when rd_pend_q.
  logic             rd_pend_q;
  logic [IDX_W-1:0] rd_idx_q;

  logic                hit_q, free_q;
  logic [IDX_W-1:0]    hit_idx_q, free_idx_q;
  logic [HANDLE_W-1:0] hit_handle_q;

  logic [STATUS_W-1:0] status_q;
  logic [HANDLE_W-1:0] hout_q;
  logic [SLOT_W-1:0]   slot_q;

  logic [WORD_W-1:0]   rdata;
  logic                rd_valid;
  logic [KEY_W-1:0]    rd_key;
  logic [HANDLE_W-1:0] rd_handle;
  logic                rd_match;

  logic [STATUS_W-1:0] status_d;
  logic [HANDLE_W-1:0] hout_d;
  logic [IDX_W-1:0]    slot_d;
  logic                upd;
  logic                upd_valid;
  logic [IDX_W-1:0]    upd_idx;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;

  assign rd_valid  = rdata[WORD_W-1];
  assign rd_key    = rdata[HANDLE_W +: KEY_W];
  assign rd_handle = rdata[HANDLE_W-1:0];
  assign rd_match  = rd_valid && (rd_key == key_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      key_q    <= key_i;
      handle_q <= handle_i;
    end
    rd_idx_q <= addr_i;
    if (rd_pend_q && rd_match && !hit_q) begin
      hit_idx_q    <= rd_idx_q;
      hit_handle_q <= rd_handle;
    end
    if (rd_pend_q && !rd_valid && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (cmd_i.resp) begin
      status_q <= status_d;
      hout_q   <= hout_d;
      slot_q   <= SLOT_W'(slot_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd;
      if (cmd_i.load) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (rd_pend_q) begin
        if (rd_match) begin
          hit_q <= 1'b1;
        end
        if (!rd_valid) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  // Result and write-back. An unused kind code behaves as a lookup.
  always_comb begin
    status_d  = STAT_MISS;
    hout_d    = '0;
    slot_d    = '0;
    upd       = 1'b0;
    upd_valid = 1'b0;
    upd_idx   = hit_idx_q;
    case (kind_q)
      KIND_INSERT: begin
        if (hit_q) begin
          status_d = STAT_DUP;
        end else if (!free_q) begin
          status_d = STAT_FULL;
        end else begin
          status_d  = STAT_OK;
          slot_d    = free_idx_q;
          upd       = 1'b1;
          upd_valid = 1'b1;
          upd_idx   = free_idx_q;
        end
      end
      KIND_REMOVE: begin
        if (hit_q) begin
          status_d = STAT_OK;
          hout_d   = hit_handle_q;
          slot_d   = hit_idx_q;
          upd      = 1'b1;
        end
      end
      default: begin
        if (hit_q) begin
          status_d = STAT_OK;
          hout_d   = hit_handle_q;
          slot_d   = hit_idx_q;
        end
      end
    endcase
  end

  assign we    = cmd_i.wipe || (cmd_i.resp && upd);
  assign waddr = cmd_i.wipe ? addr_i : upd_idx;
  assign wdata = cmd_i.wipe ? '0 : {upd_valid, key_q, handle_q};

  kst_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd),
    .raddr_i(addr_i),
    .rdata_o(rdata)
  );

  assign status_o     = status_q;
  assign handle_out_o = hout_q;
  assign slot_o       = slot_q;

endmodule

[sv/keyed_slot_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed slot table unit
// A table of slots, each with a valid mark, a key and a handle, serving
// lookup, insert (lowest free slot) and remove requests.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake        Payload
//   request   start / busy     kind_i, key_i, handle_i
//   result    done_o (strobe)  status_o, handle_out_o, slot_o
//
// A request is taken at a rising edge with start high and busy low. The
// controller then walks the slot memory one address per cycle; the single read
// port of the slot memory sets that pace. The result strobe follows the scan,
// a drain state, a response state and the strobe register. A new request
// may be started in the very cycle that the result is shown.
// After reset the unit writes an empty slot at every address of the memory,
// with busy held high. The result is shown for one cycle only: the
// receiver cannot stall it, and nothing else waits on it.
//
module keyed_slot_table_unit import kst_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [HANDLE_W-1:0] handle_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [HANDLE_W-1:0] handle_out_o,
  output logic [SLOT_W-1:0]   slot_o
);

  kst_cmd_t                   cmd;
  logic [$clog2(ENTRIES)-1:0] addr;

  // The controller owns sequencing only: it steps the scan address and
  // issues commands. Every key comparison and the table itself sit in the
  // datapath.
  kst_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .done_o(done_o),
    .cmd_o (cmd),
    .addr_o(addr)
  );

  // The datapath keeps the first matching slot and the first free slot seen
  // during the scan; since the scan runs upward, the first seen is the lowest.
  kst_dpath #(
    .ENTRIES(ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .kind_i      (kind_i),
    .key_i       (key_i),
    .handle_i    (handle_i),
    .status_o    (status_o),
    .handle_out_o(handle_out_o),
    .slot_o      (slot_o)
  );

  // A result strobe is never repeated on the next cycle: each transaction
  // takes a full scan.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // An accepted request keeps the unit busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("unit not busy after accepting a request");

  // The result is shown only once the unit is free again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while unit busy");

  // A refused or missed request carries a zero handle and slot.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STAT_OK)) |-> (handle_out_o == '0 && slot_o == '0))
    else $error("non-zero payload on a failed request");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed slot table unit testbench
// Drives lookup, insert and remove requests through the start/busy handshake.
// A local table model predicts every result. Each done_o strobe is checked
// against the oldest outstanding prediction. Directed cases come first:
// an empty table, a handle of zero, duplicate keys, first-free refill, a full
// table and the spare operation code. Then come long random runs that swing
// the table between empty and full, the last of them with no idle cycles.
// ----------------------------------------------------------------------------
module tb_top;
  import kst_pkg::*;

  localparam int ENTRIES   = ENTRIES_DEF;
  localparam int POOL_SIZE = ENTRIES + ENTRIES / 2;
  // The longest quiet stretch in a correct run is the clearing pass after
  // reset, or one request's latency plus an idle burst. The watchdog allows
  // many times either of them.
  localparam int STALL_LIMIT = 10 * (ENTRIES + 10);

  // Operation code 3 has no name in the package. The unit treats it as a
  // lookup.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
  } table_result_t;

  // Clock, reset and the request side are all driven from the bench.
  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                start    = 1'b0;
  logic [KIND_W-1:0]   kind_i   = KIND_LOOKUP;
  logic [KEY_W-1:0]    key_i    = '0;
  logic [HANDLE_W-1:0] handle_i = '0;

  logic                busy;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [HANDLE_W-1:0] handle_out_o;
  logic [SLOT_W-1:0]   slot_o;

  // This is the bench's own copy of the slot table. The model updates it at
  // the moment each request is accepted.
  bit                  tbl_valid  [ENTRIES];
  logic [KEY_W-1:0]    tbl_key    [ENTRIES];
  logic [HANDLE_W-1:0] tbl_handle [ENTRIES];
  int                  tbl_count;

  table_result_t       pending_results[$];
  logic [KEY_W-1:0]    key_pool[POOL_SIZE];

  int  error_count  = 0;
  int  stall_cycles = 0;
  bit  idling_on    = 1'b1;
  bit  filling      = 1'b1;

  keyed_slot_table_unit #(
    .ENTRIES(ENTRIES)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .key_i       (key_i),
    .handle_i    (handle_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .handle_out_o(handle_out_o),
    .slot_o      (slot_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Only the first ten failures are printed. All of them are counted.
  task automatic report_failure(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  // This models one request against the local table and queues the result
  // it must give. The key match and the free slot search both take the
  // lowest index. An insert looks for a duplicate before it looks for room,
  // so on a full table a present key reports a duplicate, not full.
  task automatic predict_request(input logic [KIND_W-1:0]   kind,
                                 input logic [KEY_W-1:0]    key,
                                 input logic [HANDLE_W-1:0] hnd);
    table_result_t res;
    int            hit;
    int            free_idx;
    int            i;
    res.status = STAT_MISS;
    res.handle = '0;
    res.slot   = '0;
    hit        = -1;
    free_idx   = -1;
    for (i = ENTRIES - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_key[i] == key) hit = i;
      if (!tbl_valid[i]) free_idx = i;
    end
    case (kind)
      KIND_INSERT: begin
        if (hit >= 0) begin
          res.status = STAT_DUP;
        end else if (free_idx < 0) begin
          res.status = STAT_FULL;
        end else begin
          tbl_valid[free_idx]  = 1'b1;
          tbl_key[free_idx]    = key;
          tbl_handle[free_idx] = hnd;
          tbl_count++;
          res.status = STAT_OK;
          res.slot   = SLOT_W'(free_idx);
        end
      end
      KIND_REMOVE: begin
        if (hit >= 0) begin
          res.status     = STAT_OK;
          res.handle     = tbl_handle[hit];
          res.slot       = SLOT_W'(hit);
          tbl_valid[hit] = 1'b0;
          tbl_count--;
        end
      end
      default: begin
        // Lookup, and the spare code, which behaves the same way.
        if (hit >= 0) begin
          res.status = STAT_OK;
          res.handle = tbl_handle[hit];
          res.slot   = SLOT_W'(hit);
        end
      end
    endcase
    pending_results.push_back(res);
  endtask

  // This sends one request transaction. Start stays high from one request
  // to the next unless an idle burst falls between them. Half of the bursts
  // wait for the unit to become ready first, so that the unit itself sits
  // idle. The others are absorbed while it is still busy. The task returns
  // in the time step of the accepting edge.
  task automatic send_request(input logic [KIND_W-1:0]   kind,
                              input logic [KEY_W-1:0]    key,
                              input logic [HANDLE_W-1:0] hnd);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk_i); while (busy !== 1'b0);
      end
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    kind_i   <= kind;
    key_i    <= key;
    handle_i <= hnd;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_request(kind, key, hnd);
  endtask

  // The directed cases start on an empty table. They cover misses, the
  // extreme keys and handles, a handle of zero held as an ordinary value,
  // duplicate inserts, reuse of the lowest freed slot and the spare code.
  task automatic test_directed_basics();
    send_request(KIND_LOOKUP, 16'h0000, 16'h0000);
    send_request(KIND_REMOVE, 16'hFFFF, 16'hFFFF);
    send_request(KIND_SPARE,  16'h0000, 16'h0000);
    send_request(KIND_INSERT, 16'h0000, 16'h0000);
    send_request(KIND_INSERT, 16'hFFFF, 16'hFFFF);
    send_request(KIND_INSERT, 16'h0000, 16'h1234);
    send_request(KIND_LOOKUP, 16'h0000, 16'hFFFF);
    send_request(KIND_SPARE,  16'hFFFF, 16'h0000);
    send_request(KIND_INSERT, 16'h5555, 16'hAAAA);
    send_request(KIND_INSERT, 16'hAAAA, 16'h5555);
    send_request(KIND_REMOVE, 16'h0000, 16'hFFFF);
    send_request(KIND_LOOKUP, 16'h0000, 16'h0000);
    send_request(KIND_REMOVE, 16'h0000, 16'h0000);
    send_request(KIND_INSERT, 16'h0001, 16'hFFFF);
    send_request(KIND_REMOVE, 16'h5555, 16'h0000);
    send_request(KIND_INSERT, 16'h0002, 16'h0001);
    send_request(KIND_LOOKUP, 16'hAAAA, 16'h0000);
    send_request(KIND_SPARE,  16'h1234, 16'hFFFF);
    send_request(KIND_INSERT, 16'hFFFF, 16'h0000);
    send_request(KIND_REMOVE, 16'hFFFF, 16'h5A5A);
  endtask

  // This fills every slot, then pushes against the limit. It sends new keys
  // while full, then a duplicate while full, a hit in the top slot, and a
  // remove from the middle followed by an insert that must land there.
  task automatic test_fill_to_capacity();
    int idx;
    idx = 0;
    while (tbl_count < ENTRIES) begin
      send_request(KIND_INSERT, key_pool[idx % POOL_SIZE], 16'($urandom));
      idx++;
    end
    repeat (3) send_request(KIND_INSERT, 16'($urandom), 16'($urandom));
    send_request(KIND_INSERT, tbl_key[ENTRIES - 1], 16'($urandom));
    send_request(KIND_LOOKUP, tbl_key[ENTRIES - 1], 16'($urandom));
    send_request(KIND_REMOVE, tbl_key[ENTRIES / 2], 16'($urandom));
    send_request(KIND_INSERT, 16'($urandom), 16'($urandom));
  endtask

  // This sends a random mix that is mostly well formed. A fill phase favours
  // inserts and a drain phase favours removes, so the table swings between
  // empty and full. Removes and lookups usually name a key that is stored.
  // A small share is noise: any code with any key.
  task automatic test_random_traffic(input int n_items);
    int                  n;
    int                  roll;
    int                  pick;
    logic [KIND_W-1:0]   kind;
    logic [KEY_W-1:0]    key;
    for (n = 0; n < n_items; n++) begin
      if (tbl_count == 0) filling = 1'b1;
      else if (tbl_count == ENTRIES && $urandom_range(0, 3) == 0) filling = 1'b0;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, ENTRIES - 1);
      if (roll < 8) begin
        kind = KIND_W'($urandom_range(0, 3));
        key  = 16'($urandom);
      end else begin
        if (roll < 20)     kind = KIND_LOOKUP;
        else if (roll < 25) kind = KIND_SPARE;
        else if (roll < 80) kind = filling ? KIND_INSERT : KIND_REMOVE;
        else                kind = filling ? KIND_REMOVE : KIND_INSERT;
        if (kind != KIND_INSERT && tbl_valid[pick] && $urandom_range(0, 3) != 0) begin
          key = tbl_key[pick];
        end else begin
          key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
      end
      send_request(kind, key, 16'($urandom));
    end
  endtask

  // The last stretch runs with start held high throughout, so each request
  // follows its predecessor as soon as the unit allows.
  task automatic test_back_to_back();
    idling_on = 1'b0;
    test_random_traffic(250);
  endtask

  // This is the result checker. Each strobe consumes the oldest prediction.
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_failure($sformatf("unexpected result: status %0d handle %h slot %0d",
                                 status_o, handle_out_o, slot_o));
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || handle_out_o !== want.handle ||
            slot_o !== want.slot) begin
          report_failure($sformatf(
            "mismatch: expected status %0d handle %h slot %0d, got status %0d handle %h slot %0d",
            want.status, want.handle, want.slot, status_o, handle_out_o, slot_o));
        end
      end
    end
  end

  // The watchdog restarts its count on any accepted transaction or result.
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int base;
    tbl_count = 0;
    for (i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
    // Multiplying by an odd constant and XORing with a base are both
    // one-to-one on 16 bits, so every key in the pool is distinct.
    base = $urandom;
    for (i = 0; i < POOL_SIZE; i++) key_pool[i] = 16'(i * 16'h9E37) ^ 16'(base);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_basics();
    test_fill_to_capacity();
    test_random_traffic(1000);
    test_back_to_back();

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // Give a stray strobe time to show after the last expected one.
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
